[design/srwr_pkg.sv]
// ============================================================================
// srwr_pkg
// Shared types and constants for the selective-repeat window receiver.
// ============================================================================
package srwr_pkg;

  localparam int SEQ_W    = 27;
  localparam int LEN_W    = 10;
  localparam int SLOT_W   = 7;
  localparam int OFS_W    = 17;
  localparam int BYTES_W  = 17;
  localparam int SLOT_BYTES_W = 16;

  localparam int DEF_WINDOW_SLOTS = 128;
  localparam int DEF_SLOT_BYTES   = 1008;

  typedef enum logic [1:0] {
    ACT_DROP  = 2'd0,
    ACT_ACK   = 2'd1,
    ACT_STORE = 2'd2,
    ACT_FIN   = 2'd3
  } action_t;

  typedef struct packed {
    logic             is_fin;
    logic [SEQ_W-1:0] seq_no;
    logic [LEN_W-1:0] data_len;
  } item_t;

  typedef struct packed {
    action_t            action;
    logic [SEQ_W-1:0]   ack_no;
    logic [SLOT_W-1:0]  slot_index;
    logic [OFS_W-1:0]   byte_offset;
    logic               window_done;
    logic [BYTES_W-1:0] window_bytes;
    logic               finished;
  } result_t;

endpackage

[design/selective_repeat_window_receiver.sv]
// ============================================================================
// selective_repeat_window_receiver
// Receiver window tracker for a selective-repeat ARQ link.
// ============================================================================
// Each header transaction yields exactly one result transaction, in order.
// The block sustains one transaction per cycle on both sides while the
// result queue is not full; a result reaches the output once its header
// has passed the command queue register that captures the header and the
// result queue register that captures the result of the window logic
// between them. The window logic does one bitmap read-modify-write per
// cycle, and that update sets the rate.
module selective_repeat_window_receiver #(
  parameter int WINDOW_SLOTS = srwr_pkg::DEF_WINDOW_SLOTS,
  parameter int SLOT_BYTES   = srwr_pkg::DEF_SLOT_BYTES
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_push,
  output logic                         in_full,
  input  logic                         in_is_fin,
  input  logic [srwr_pkg::SEQ_W-1:0]   in_seq_no,
  input  logic [srwr_pkg::LEN_W-1:0]   in_data_len,
  output logic                         out_empty,
  input  logic                         out_pop,
  output logic [1:0]                   out_action,
  output logic [srwr_pkg::SEQ_W-1:0]   out_ack_no,
  output logic [srwr_pkg::SLOT_W-1:0]  out_slot_index,
  output logic [srwr_pkg::OFS_W-1:0]   out_byte_offset,
  output logic                         out_window_done,
  output logic [srwr_pkg::BYTES_W-1:0] out_window_bytes,
  output logic                         out_finished
);
  import srwr_pkg::*;

  localparam int ITEM_W   = $bits(item_t);
  localparam int RESULT_W = $bits(result_t);

  logic    cq_push;
  logic    cq_full;
  logic    cq_empty;
  logic    cq_pop;
  item_t   cq_din;
  item_t   cq_dout;
  logic    rq_push;
  logic    rq_full;
  result_t rq_din;
  result_t rq_dout;

  srwr_front #(
    .SLOT_BYTES(SLOT_BYTES)
  ) u_front (
    .in_push     (in_push),
    .in_full     (in_full),
    .in_is_fin   (in_is_fin),
    .in_seq_no   (in_seq_no),
    .in_data_len (in_data_len),
    .q_push      (cq_push),
    .q_item      (cq_din),
    .q_full      (cq_full)
  );

  srwr_fifo #(
    .WIDTH(ITEM_W)
  ) u_cmd_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (cq_push),
    .din   (cq_din),
    .full  (cq_full),
    .pop   (cq_pop),
    .dout  (cq_dout),
    .empty (cq_empty)
  );

  srwr_back #(
    .WINDOW_SLOTS(WINDOW_SLOTS),
    .SLOT_BYTES  (SLOT_BYTES)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_empty  (cq_empty),
    .q_item   (cq_dout),
    .q_pop    (cq_pop),
    .r_full   (rq_full),
    .r_push   (rq_push),
    .r_result (rq_din)
  );

  srwr_fifo #(
    .WIDTH(RESULT_W)
  ) u_res_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (rq_push),
    .din   (rq_din),
    .full  (rq_full),
    .pop   (out_pop),
    .dout  (rq_dout),
    .empty (out_empty)
  );

  assign out_action       = rq_dout.action;
  assign out_ack_no       = rq_dout.ack_no;
  assign out_slot_index   = rq_dout.slot_index;
  assign out_byte_offset  = rq_dout.byte_offset;
  assign out_window_done  = rq_dout.window_done;
  assign out_window_bytes = rq_dout.window_bytes;
  assign out_finished     = rq_dout.finished;

endmodule

[design/srwr_fifo.sv]
// ============================================================================
// srwr_fifo
// Two-entry queue with push/full and pop/empty handshakes.
// ============================================================================
module srwr_fifo #(
  parameter int WIDTH = 1
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] din,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] dout,
  output logic             empty
);

  logic [WIDTH-1:0] mem_r [2];
  logic             wr_ptr_r;
  logic             wr_ptr_nxt;
  logic             rd_ptr_r;
  logic             rd_ptr_nxt;
  logic [1:0]       count_r;
  logic [1:0]       count_nxt;
  logic             do_push;
  logic             do_pop;

  assign full    = (count_r == 2'd2);
  assign empty   = (count_r == 2'd0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = do_push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop ? !rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 2'd1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= din;
    end
  end

endmodule

[design/srwr_front.sv]
// ============================================================================
// srwr_front
// Accepts packet headers, clamps the length to the slot size and hands the
// item to the command queue.
// ============================================================================
module srwr_front #(
  parameter int SLOT_BYTES = srwr_pkg::DEF_SLOT_BYTES
) (
  input  logic                       in_push,
  output logic                       in_full,
  input  logic                       in_is_fin,
  input  logic [srwr_pkg::SEQ_W-1:0] in_seq_no,
  input  logic [srwr_pkg::LEN_W-1:0] in_data_len,
  output logic                       q_push,
  output srwr_pkg::item_t            q_item,
  input  logic                       q_full
);
  import srwr_pkg::*;

  localparam logic [SLOT_BYTES_W:0] SLOT_LIMIT = (SLOT_BYTES_W + 1)'(SLOT_BYTES);

  logic oversize;

  assign oversize = ((SLOT_BYTES_W + 1)'(in_data_len) > SLOT_LIMIT);
  assign in_full  = q_full;
  assign q_push   = in_push;

  always_comb begin
    q_item.is_fin   = in_is_fin;
    q_item.seq_no   = in_seq_no;
    q_item.data_len = oversize ? LEN_W'(SLOT_LIMIT) : in_data_len;
  end

endmodule

[design/srwr_back.sv]
// ============================================================================
// srwr_back
// Holds the window state, decides the action for each queued item and
// produces one result per item.
// ============================================================================
module srwr_back #(
  parameter int WINDOW_SLOTS = srwr_pkg::DEF_WINDOW_SLOTS,
  parameter int SLOT_BYTES   = srwr_pkg::DEF_SLOT_BYTES
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_empty,
  input  srwr_pkg::item_t   q_item,
  output logic              q_pop,
  input  logic              r_full,
  output logic              r_push,
  output srwr_pkg::result_t r_result
);
  import srwr_pkg::*;

  localparam int IDX_W  = (WINDOW_SLOTS > 1) ? $clog2(WINDOW_SLOTS) : 1;
  localparam int PROD_W = IDX_W + SLOT_BYTES_W;
  localparam logic [SLOT_BYTES_W-1:0] SLOT_BYTES_C = SLOT_BYTES_W'(SLOT_BYTES);
  localparam logic [IDX_W-1:0]        LAST_COUNT   = IDX_W'(WINDOW_SLOTS - 1);

  logic [SEQ_W-1:0]        base_r;
  logic [SEQ_W-1:0]        base_nxt;
  logic [WINDOW_SLOTS-1:0] bitmap_r;
  logic [WINDOW_SLOTS-1:0] bitmap_nxt;
  logic [IDX_W-1:0]        count_r;
  logic [IDX_W-1:0]        count_nxt;
  logic [BYTES_W-1:0]      total_r;
  logic [BYTES_W-1:0]      total_nxt;
  logic                    session_r;
  logic                    session_nxt;

  logic                    fire;
  logic [SEQ_W:0]          window_end;
  logic [SEQ_W-1:0]        diff;
  logic [IDX_W-1:0]        idx;
  logic [PROD_W-1:0]       prod;
  logic [BYTES_W-1:0]      total_sum;

  assign fire       = !q_empty && !r_full;
  assign q_pop      = fire;
  assign r_push     = fire;
  assign window_end = {1'b0, base_r} + (SEQ_W + 1)'(WINDOW_SLOTS);
  assign diff       = q_item.seq_no - base_r;
  assign idx        = diff[IDX_W-1:0];
  assign prod       = PROD_W'(idx) * PROD_W'(SLOT_BYTES_C);
  assign total_sum  = total_r + BYTES_W'(q_item.data_len);

  always_comb begin
    base_nxt    = base_r;
    bitmap_nxt  = bitmap_r;
    count_nxt   = count_r;
    total_nxt   = total_r;
    session_nxt = session_r;
    r_result    = '0;
    r_result.action = ACT_DROP;
    priority if (session_r) begin
      r_result.finished = 1'b1;
    end else if (q_item.is_fin) begin
      session_nxt           = 1'b1;
      r_result.action       = ACT_FIN;
      r_result.window_done  = 1'b1;
      r_result.window_bytes = total_r;
      r_result.finished     = 1'b1;
    end else if (q_item.seq_no < base_r) begin
      r_result.action = ACT_ACK;
      r_result.ack_no = q_item.seq_no;
    end else if ({1'b0, q_item.seq_no} >= window_end) begin
      r_result.action = ACT_DROP;
    end else if (bitmap_r[idx]) begin
      r_result.action = ACT_ACK;
      r_result.ack_no = q_item.seq_no;
    end else begin
      r_result.action      = ACT_STORE;
      r_result.ack_no      = q_item.seq_no;
      r_result.slot_index  = SLOT_W'(idx);
      r_result.byte_offset = prod[OFS_W-1:0];
      bitmap_nxt[idx]      = 1'b1;
      count_nxt            = count_r + IDX_W'(1);
      total_nxt            = total_sum;
      if (count_r == LAST_COUNT) begin
        r_result.window_done  = 1'b1;
        r_result.window_bytes = total_sum;
        base_nxt              = base_r + SEQ_W'(WINDOW_SLOTS);
        bitmap_nxt            = '0;
        count_nxt             = '0;
        total_nxt             = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r    <= '0;
      bitmap_r  <= '0;
      count_r   <= '0;
      total_r   <= '0;
      session_r <= 1'b0;
    end else if (fire) begin
      base_r    <= base_nxt;
      bitmap_r  <= bitmap_nxt;
      count_r   <= count_nxt;
      total_r   <= total_nxt;
      session_r <= session_nxt;
    end
  end

endmodule
